FILE: hdl/priority_task_scheduler_with_counters_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority task scheduler
// Shared shorthand for the concurrent checks in the scheduler modules.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_SCHEDULER_WITH_COUNTERS_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_WITH_COUNTERS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, codes and default sizes of the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	// Default sizes.
	localparam int NUM_SLOTS_DEF           = 16;
	localparam int NUM_COUNTERS_DEF        = 8;
	localparam int WAITERS_PER_COUNTER_DEF = 4;

	// Command codes on the request channel.
	typedef enum logic [2:0] {
		MODE_SUBMIT   = 3'd0,
		MODE_DISPATCH = 3'd1,
		MODE_DONE     = 3'd2,
		MODE_WAIT     = 3'd3,
		MODE_SET      = 3'd4
	} mode_t;

	// Result status codes.
	typedef enum logic [2:0] {
		STS_OK           = 3'd0,
		STS_NO_SLOT      = 3'd1,
		STS_NONE_READY   = 3'd2,
		STS_RESUME       = 3'd3,
		STS_PARKED       = 3'd4,
		STS_WAITERS_FULL = 3'd5
	} status_t;

	// Ready queue selects, by priority.
	localparam logic [1:0] PRIO_HIGH = 2'd0;
	localparam logic [1:0] PRIO_MID  = 2'd1;
	localparam logic [1:0] PRIO_LOW  = 2'd2;
	localparam logic [1:0] PRIO_BAD  = 2'd3;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SUB_WRITE,
		ST_DIS_SLOT,
		ST_DIS_TAG,
		ST_DONE_UPD,
		ST_WAKE_LIST,
		ST_WAKE_SLOT,
		ST_WAKE_ENQ,
		ST_FIN
	} state_t;

	// Datapath commands issued by the controller.
	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_SUB_READ,
		CMD_SUB_WRITE,
		CMD_SUB_FULL,
		CMD_DIS_READ,
		CMD_DIS_NONE,
		CMD_DIS_SLOT,
		CMD_DIS_TAG,
		CMD_DONE_READ,
		CMD_DONE_UPDATE,
		CMD_WAIT,
		CMD_SET,
		CMD_WAKE_LIST,
		CMD_WAKE_SLOT,
		CMD_WAKE_ENQ,
		CMD_LOAD_OUT
	} cmd_t;

	// Datapath flags seen by the controller.
	typedef struct packed {
		logic [2:0] mode;
		logic       free_empty;
		logic       ready_none;
		logic       tid_ok;
		logic       wake_go;
		logic       wake_more;
		logic       out_free;
	} dp_status_t;

endpackage

FILE: hdl/pts_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_req_if
// Request channel of the scheduler: one command per transfer.
// ----------------------------------------------------------------------------
interface pts_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [1:0]  priority_req;
	logic [31:0] job_tag;
	logic        has_counter;
	logic [2:0]  counter_id;
	logic [3:0]  task_id;
	logic [15:0] count_value;

	modport source (output valid, mode, priority_req, job_tag, has_counter, counter_id,
		task_id, count_value, input ready);
	modport sink (input valid, mode, priority_req, job_tag, has_counter, counter_id,
		task_id, count_value, output ready);
endinterface

FILE: hdl/pts_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_rsp_if
// Response channel of the scheduler: one result per transfer.
// ----------------------------------------------------------------------------
interface pts_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  out_task;
	logic [31:0] out_tag;
	logic [2:0]  woken;

	modport source (output valid, status, out_task, out_tag, woken, input ready);
	modport sink (input valid, status, out_task, out_tag, woken, output ready);
endinterface

FILE: hdl/pts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ctrl
// Command sequencer: steps the datapath through each scheduler command.
// ----------------------------------------------------------------------------
module pts_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  pts_pkg::dp_status_t   st,
	output pts_pkg::cmd_t         cmd
);

	pts_pkg::state_t state_q;
	pts_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pts_pkg::ST_IDLE: begin
				if (req_valid) state_d = pts_pkg::ST_DECODE;
			end
			pts_pkg::ST_DECODE: begin
				case (st.mode)
					pts_pkg::MODE_SUBMIT: begin
						state_d = st.free_empty ? pts_pkg::ST_FIN : pts_pkg::ST_SUB_WRITE;
					end
					pts_pkg::MODE_DISPATCH: begin
						state_d = st.ready_none ? pts_pkg::ST_FIN : pts_pkg::ST_DIS_SLOT;
					end
					pts_pkg::MODE_DONE: begin
						state_d = st.tid_ok ? pts_pkg::ST_DONE_UPD : pts_pkg::ST_FIN;
					end
					default: state_d = pts_pkg::ST_FIN;
				endcase
			end
			pts_pkg::ST_SUB_WRITE: state_d = pts_pkg::ST_FIN;
			pts_pkg::ST_DIS_SLOT:  state_d = pts_pkg::ST_DIS_TAG;
			pts_pkg::ST_DIS_TAG:   state_d = pts_pkg::ST_FIN;
			pts_pkg::ST_DONE_UPD: begin
				state_d = st.wake_go ? pts_pkg::ST_WAKE_LIST : pts_pkg::ST_FIN;
			end
			pts_pkg::ST_WAKE_LIST: state_d = pts_pkg::ST_WAKE_SLOT;
			pts_pkg::ST_WAKE_SLOT: state_d = pts_pkg::ST_WAKE_ENQ;
			pts_pkg::ST_WAKE_ENQ: begin
				state_d = st.wake_more ? pts_pkg::ST_WAKE_LIST : pts_pkg::ST_FIN;
			end
			pts_pkg::ST_FIN: begin
				if (st.out_free) state_d = pts_pkg::ST_IDLE;
			end
			default: state_d = pts_pkg::ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd       = pts_pkg::CMD_NONE;
		req_ready = 1'b0;
		case (state_q)
			pts_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) cmd = pts_pkg::CMD_LATCH;
			end
			pts_pkg::ST_DECODE: begin
				case (st.mode)
					pts_pkg::MODE_SUBMIT: begin
						cmd = st.free_empty ? pts_pkg::CMD_SUB_FULL : pts_pkg::CMD_SUB_READ;
					end
					pts_pkg::MODE_DISPATCH: begin
						cmd = st.ready_none ? pts_pkg::CMD_DIS_NONE : pts_pkg::CMD_DIS_READ;
					end
					pts_pkg::MODE_DONE: begin
						cmd = st.tid_ok ? pts_pkg::CMD_DONE_READ : pts_pkg::CMD_NONE;
					end
					pts_pkg::MODE_WAIT: cmd = pts_pkg::CMD_WAIT;
					pts_pkg::MODE_SET:  cmd = pts_pkg::CMD_SET;
					default:            cmd = pts_pkg::CMD_NONE;
				endcase
			end
			pts_pkg::ST_SUB_WRITE: cmd = pts_pkg::CMD_SUB_WRITE;
			pts_pkg::ST_DIS_SLOT:  cmd = pts_pkg::CMD_DIS_SLOT;
			pts_pkg::ST_DIS_TAG:   cmd = pts_pkg::CMD_DIS_TAG;
			pts_pkg::ST_DONE_UPD:  cmd = pts_pkg::CMD_DONE_UPDATE;
			pts_pkg::ST_WAKE_LIST: cmd = pts_pkg::CMD_WAKE_LIST;
			pts_pkg::ST_WAKE_SLOT: cmd = pts_pkg::CMD_WAKE_SLOT;
			pts_pkg::ST_WAKE_ENQ:  cmd = pts_pkg::CMD_WAKE_ENQ;
			pts_pkg::ST_FIN: begin
				if (st.out_free) cmd = pts_pkg::CMD_LOAD_OUT;
			end
			default: cmd = pts_pkg::CMD_NONE;
		endcase
	end

endmodule

FILE: hdl/pts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_dp
// Scheduler datapath: free pool, slot table, ready queues, counters,
// waiter lists and the output register.
// ----------------------------------------------------------------------------
`include "priority_task_scheduler_with_counters_defines.svh"

module pts_dp #(
	parameter int NUM_SLOTS           = pts_pkg::NUM_SLOTS_DEF,
	parameter int NUM_COUNTERS        = pts_pkg::NUM_COUNTERS_DEF,
	parameter int WAITERS_PER_COUNTER = pts_pkg::WAITERS_PER_COUNTER_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pts_pkg::cmd_t       cmd,
	output pts_pkg::dp_status_t st,
	input  logic [2:0]          mode,
	input  logic [1:0]          priority_req,
	input  logic [31:0]         job_tag,
	input  logic                has_counter,
	input  logic [2:0]          counter_id,
	input  logic [3:0]          task_id,
	input  logic [15:0]         count_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [3:0]          out_task,
	output logic [31:0]         out_tag,
	output logic [2:0]          woken
);

	localparam int SW       = $clog2(NUM_SLOTS);
	localparam int FW       = $clog2(NUM_SLOTS + 1);
	localparam int CW       = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
	localparam int WCW      = $clog2(WAITERS_PER_COUNTER + 1);
	localparam int WL_DEPTH = NUM_COUNTERS * WAITERS_PER_COUNTER;
	localparam int LAW      = (WL_DEPTH > 1) ? $clog2(WL_DEPTH) : 1;
	localparam int Q_DEPTH  = 3 * NUM_SLOTS;
	localparam int QAW      = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [31:0]   tag;
		logic [1:0]    prio;
		logic          hc;
		logic [CW-1:0] ctr;
	} slot_rec_t;

	// Latched command.
	logic [2:0]  mode_q;
	logic [1:0]  prio_q;
	logic [31:0] tag_q;
	logic        hc_q;
	logic [2:0]  cid_q;
	logic [3:0]  tid_q;
	logic [15:0] val_q;

	// Free pool.
	logic [SW-1:0]        fp_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] fp_wr_q;
	logic [SW-1:0]        free_head_q;
	logic [FW-1:0]        free_count_q;
	logic [SW-1:0]        fp_rd_q;
	logic                 fp_rdv_q;
	logic [SW-1:0]        fp_radr_q;
	logic [SW-1:0]        free_slot;
	logic [SW:0]          fp_tail_sum;
	logic [SW-1:0]        fp_tail;
	logic [SW-1:0]        head_inc;
	logic                 fp_push;

	// Slot table.
	slot_rec_t            si_mem [NUM_SLOTS];
	slot_rec_t            si_rd_q;
	logic [NUM_SLOTS-1:0] alloc_q;
	logic [SW-1:0]        si_raddr;

	// Ready queues.
	logic [SW-1:0] q_mem [Q_DEPTH];
	logic [SW-1:0] head_q [3];
	logic [FW-1:0] fill_q [3];
	logic [SW-1:0] q_rd_q;
	logic [2:0]    nonempty;
	logic [1:0]    deq_sel;
	logic          enq_en;
	logic [1:0]    enq_prio_raw;
	logic [1:0]    enq_q;
	logic [SW-1:0] enq_slot;
	logic [1:0]    ptr_sel;
	logic [SW-1:0] sel_head;
	logic [FW-1:0] sel_fill;
	logic          enq_ok;
	logic [SW:0]   enq_sum;
	logic [SW-1:0] enq_pos;
	logic [SW-1:0] head_next;
	logic [QAW-1:0] q_waddr;
	logic [QAW-1:0] q_raddr;

	// Counters and waiter lists.
	logic [15:0]    cv_q [NUM_COUNTERS];
	logic [WCW-1:0] wc_q [NUM_COUNTERS];
	logic [SW-1:0]  wl_mem [WL_DEPTH];
	logic [SW-1:0]  wl_rd_q;
	logic [CW-1:0]  cnt_sel;
	logic [15:0]    cv_sel;
	logic [WCW-1:0] wc_sel;
	logic           dn_has;
	logic           dn_dec;
	logic           dn_zero;
	logic [WCW-1:0] wk_cnt;
	logic           wait_live;
	logic           wait_full;
	logic           wait_park;
	logic [LAW-1:0] wl_waddr;
	logic [LAW-1:0] wl_raddr;
	logic [CW-1:0]  wk_c_q;
	logic [WCW-1:0] wk_n_q;
	logic [WCW-1:0] wk_i_q;
	logic [WCW-1:0] wk_i_inc;

	// Result and output registers.
	logic [2:0]  res_status;
	logic [3:0]  res_task;
	logic [31:0] res_tag;
	logic [2:0]  res_woken;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [3:0]  out_task_q;
	logic [31:0] out_tag_q;
	logic [2:0]  woken_q;

	logic [CW-1:0] cidx;
	logic [SW-1:0] tidx;
	logic          cid_ok;
	logic          tid_ok;

	// Capture the command; a priority of three queues as low.
	always_ff @(posedge clk) begin
		if (cmd == pts_pkg::CMD_LATCH) begin
			mode_q <= mode;
			prio_q <= (priority_req == pts_pkg::PRIO_BAD) ? pts_pkg::PRIO_LOW : priority_req;
			tag_q  <= job_tag;
			hc_q   <= has_counter;
			cid_q  <= counter_id;
			tid_q  <= task_id;
			val_q  <= count_value;
		end
	end

	// Range checks on the command's indexes.
	assign cidx   = CW'(cid_q);
	assign tidx   = SW'(tid_q);
	assign cid_ok = 32'(cid_q) < NUM_COUNTERS;
	assign tid_ok = (32'(tid_q) < NUM_SLOTS) && alloc_q[tidx];

	// Free pool addressing; an entry never written holds its own index.
	assign free_slot   = fp_rdv_q ? fp_rd_q : fp_radr_q;
	assign fp_tail_sum = (SW+1)'(free_head_q) + (SW+1)'(free_count_q);
	assign fp_tail     = (fp_tail_sum >= (SW+1)'(NUM_SLOTS)) ?
		SW'(fp_tail_sum - (SW+1)'(NUM_SLOTS)) : SW'(fp_tail_sum);
	assign head_inc    = (free_head_q == SW'(NUM_SLOTS - 1)) ? '0 : free_head_q + 1'b1;
	assign fp_push     = (cmd == pts_pkg::CMD_DONE_UPDATE) && (free_count_q < FW'(NUM_SLOTS));

	// Free pool memory.
	always_ff @(posedge clk) begin
		if (cmd == pts_pkg::CMD_SUB_READ) begin
			fp_rd_q   <= fp_mem[free_head_q];
			fp_rdv_q  <= fp_wr_q[free_head_q];
			fp_radr_q <= free_head_q;
		end
		if (fp_push) fp_mem[fp_tail] <= tidx;
	end

	// Free pool pointers and slot allocation bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_wr_q      <= '0;
			free_head_q  <= '0;
			free_count_q <= FW'(NUM_SLOTS);
			alloc_q      <= '0;
		end else begin
			if (cmd == pts_pkg::CMD_SUB_READ) begin
				free_head_q  <= head_inc;
				free_count_q <= free_count_q - 1'b1;
			end
			if (fp_push) begin
				fp_wr_q[fp_tail] <= 1'b1;
				free_count_q     <= free_count_q + 1'b1;
			end
			if (cmd == pts_pkg::CMD_SUB_WRITE) alloc_q[free_slot] <= 1'b1;
			if (cmd == pts_pkg::CMD_DONE_UPDATE) alloc_q[tidx] <= 1'b0;
		end
	end

	// Slot table read address.
	always_comb begin
		case (cmd)
			pts_pkg::CMD_DIS_SLOT:  si_raddr = q_rd_q;
			pts_pkg::CMD_WAKE_SLOT: si_raddr = wl_rd_q;
			default:                si_raddr = tidx;
		endcase
	end

	// Slot table memory.
	always_ff @(posedge clk) begin
		if (cmd == pts_pkg::CMD_DONE_READ || cmd == pts_pkg::CMD_DIS_SLOT ||
				cmd == pts_pkg::CMD_WAKE_SLOT) begin
			si_rd_q <= si_mem[si_raddr];
		end
		if (cmd == pts_pkg::CMD_SUB_WRITE) begin
			si_mem[free_slot] <= '{tag: tag_q, prio: prio_q, hc: hc_q && cid_ok, ctr: cidx};
		end
	end

	// Queue selection: dispatch takes the first queue that holds a task.
	assign nonempty[0] = fill_q[0] != '0;
	assign nonempty[1] = fill_q[1] != '0;
	assign nonempty[2] = fill_q[2] != '0;
	assign deq_sel     = nonempty[0] ? pts_pkg::PRIO_HIGH :
		(nonempty[1] ? pts_pkg::PRIO_MID : pts_pkg::PRIO_LOW);

	assign enq_en       = (cmd == pts_pkg::CMD_SUB_WRITE) || (cmd == pts_pkg::CMD_WAKE_ENQ);
	assign enq_prio_raw = (cmd == pts_pkg::CMD_WAKE_ENQ) ? si_rd_q.prio : prio_q;
	assign enq_q        = (enq_prio_raw == pts_pkg::PRIO_BAD) ? pts_pkg::PRIO_LOW : enq_prio_raw;
	assign enq_slot     = (cmd == pts_pkg::CMD_WAKE_ENQ) ? wl_rd_q : free_slot;

	// One pointer pair is read per cycle: the dequeue or the enqueue queue.
	assign ptr_sel   = (cmd == pts_pkg::CMD_DIS_READ) ? deq_sel : enq_q;
	assign sel_head  = head_q[ptr_sel];
	assign sel_fill  = fill_q[ptr_sel];
	assign enq_ok    = enq_en && (sel_fill < FW'(NUM_SLOTS));
	assign enq_sum   = (SW+1)'(sel_head) + (SW+1)'(sel_fill);
	assign enq_pos   = (enq_sum >= (SW+1)'(NUM_SLOTS)) ?
		SW'(enq_sum - (SW+1)'(NUM_SLOTS)) : SW'(enq_sum);
	assign head_next = (sel_head == SW'(NUM_SLOTS - 1)) ? '0 : sel_head + 1'b1;
	assign q_waddr   = QAW'(32'(enq_q) * NUM_SLOTS + 32'(enq_pos));
	assign q_raddr   = QAW'(32'(deq_sel) * NUM_SLOTS + 32'(sel_head));

	// Ready queue memory; a push into a full queue is dropped.
	always_ff @(posedge clk) begin
		if (enq_ok) q_mem[q_waddr] <= enq_slot;
		if (cmd == pts_pkg::CMD_DIS_READ) q_rd_q <= q_mem[q_raddr];
	end

	// Ready queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (cmd == pts_pkg::CMD_DIS_READ) begin
			head_q[deq_sel] <= head_next;
			fill_q[deq_sel] <= sel_fill - 1'b1;
		end else if (enq_ok) begin
			fill_q[enq_q] <= sel_fill + 1'b1;
		end
	end

	// Counter lookup: the finished task's counter, or the command's counter.
	assign cnt_sel   = (cmd == pts_pkg::CMD_DONE_UPDATE) ? si_rd_q.ctr : cidx;
	assign cv_sel    = cv_q[cnt_sel];
	assign wc_sel    = wc_q[cnt_sel];
	assign dn_has    = si_rd_q.hc && (32'(si_rd_q.ctr) < NUM_COUNTERS);
	assign dn_dec    = dn_has && (cv_sel != 16'd0);
	assign dn_zero   = dn_dec && (cv_sel == 16'd1);
	assign wk_cnt    = (wc_sel > WCW'(WAITERS_PER_COUNTER)) ? WCW'(WAITERS_PER_COUNTER) : wc_sel;
	assign wait_live = tid_ok && cid_ok && (cv_sel != 16'd0);
	assign wait_full = wc_sel >= WCW'(WAITERS_PER_COUNTER);
	assign wait_park = (cmd == pts_pkg::CMD_WAIT) && wait_live && !wait_full;
	assign wl_waddr  = LAW'(32'(cidx) * WAITERS_PER_COUNTER + 32'(wc_sel));
	assign wl_raddr  = LAW'(32'(wk_c_q) * WAITERS_PER_COUNTER + 32'(wk_i_q));
	assign wk_i_inc  = wk_i_q + 1'b1;

	// Counter values, waiter counts and the wake walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTERS; i++) begin
				cv_q[i] <= '0;
				wc_q[i] <= '0;
			end
			wk_c_q <= '0;
			wk_n_q <= '0;
			wk_i_q <= '0;
		end else begin
			case (cmd)
				pts_pkg::CMD_DONE_UPDATE: begin
					if (dn_dec) cv_q[cnt_sel] <= cv_sel - 16'd1;
					if (dn_zero) begin
						wc_q[cnt_sel] <= '0;
						wk_c_q        <= cnt_sel;
						wk_n_q        <= wk_cnt;
						wk_i_q        <= '0;
					end
				end
				pts_pkg::CMD_WAIT: begin
					if (wait_park) wc_q[cnt_sel] <= wc_sel + 1'b1;
				end
				pts_pkg::CMD_SET: begin
					if (cid_ok) begin
						cv_q[cnt_sel] <= val_q;
						wc_q[cnt_sel] <= '0;
					end
				end
				pts_pkg::CMD_WAKE_ENQ: wk_i_q <= wk_i_inc;
				default: ;
			endcase
		end
	end

	// Waiter list memory.
	always_ff @(posedge clk) begin
		if (wait_park) wl_mem[wl_waddr] <= tidx;
		if (cmd == pts_pkg::CMD_WAKE_LIST) wl_rd_q <= wl_mem[wl_raddr];
	end

	// Result fields, cleared when a command is taken.
	always_ff @(posedge clk) begin
		case (cmd)
			pts_pkg::CMD_LATCH: begin
				res_status <= pts_pkg::STS_OK;
				res_task   <= '0;
				res_tag    <= '0;
				res_woken  <= '0;
			end
			pts_pkg::CMD_SUB_FULL:  res_status <= pts_pkg::STS_NO_SLOT;
			pts_pkg::CMD_SUB_WRITE: res_task   <= 4'(free_slot);
			pts_pkg::CMD_DIS_NONE:  res_status <= pts_pkg::STS_NONE_READY;
			pts_pkg::CMD_DIS_SLOT:  res_task   <= 4'(q_rd_q);
			pts_pkg::CMD_DIS_TAG:   res_tag    <= si_rd_q.tag;
			pts_pkg::CMD_DONE_UPDATE: begin
				if (dn_zero) res_woken <= 3'(wk_cnt);
			end
			pts_pkg::CMD_WAIT: begin
				if (!wait_live) res_status <= pts_pkg::STS_RESUME;
				else if (wait_full) res_status <= pts_pkg::STS_WAITERS_FULL;
				else res_status <= pts_pkg::STS_PARKED;
			end
			default: ;
		endcase
	end

	// Output register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == pts_pkg::CMD_LOAD_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == pts_pkg::CMD_LOAD_OUT) begin
			status_q   <= res_status;
			out_task_q <= res_task;
			out_tag_q  <= res_tag;
			woken_q    <= res_woken;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_task  = out_task_q;
	assign out_tag   = out_tag_q;
	assign woken     = woken_q;

	// Flags for the controller.
	assign st.mode       = mode_q;
	assign st.free_empty = free_count_q == '0;
	assign st.ready_none = ~|nonempty;
	assign st.tid_ok     = tid_ok;
	assign st.wake_go    = dn_zero && (wk_cnt != '0);
	assign st.wake_more  = wk_i_inc < wk_n_q;
	assign st.out_free   = !out_valid_q || out_ready;

	// A slot is taken from the pool only when one is free.
	`PTS_ASSERT_IMP(a_sub_has_slot, clk, arst_n, cmd == pts_pkg::CMD_SUB_READ, free_count_q != '0, "submit read from an empty free pool")
	// Dispatch pops only a queue that holds a task.
	`PTS_ASSERT_IMP(a_dis_nonempty, clk, arst_n, cmd == pts_pkg::CMD_DIS_READ, fill_q[deq_sel] != '0, "dispatch from an empty ready queue")
	// The wake walk never passes the end of the captured list.
	`PTS_ASSERT_IMP(a_wake_bound, clk, arst_n, cmd == pts_pkg::CMD_WAKE_ENQ, wk_i_q < wk_n_q, "wake walk ran past the waiter list")
	// A loaded result is presented in the next cycle.
	`PTS_ASSERT_NXT(a_load_shows, clk, arst_n, cmd == pts_pkg::CMD_LOAD_OUT, out_valid_q, "loaded result not presented")

endmodule

FILE: hdl/priority_task_scheduler_with_counters.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_counters
// Strict-priority task scheduler with a slot pool, three ready queues and
// completion counters with waiter lists.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake      Carries
//  req      in         valid / ready  mode, priority_req, job_tag, has_counter,
//                                     counter_id, task_id, count_value
//  rsp      out        valid / ready  status, out_task, out_tag, woken
//
// One command is worked at a time. After the request transfer each command is
// decoded; submit then writes a slot, dispatch reads the slot and the tag, and
// a done report updates its counter and, per woken waiter, reads the list,
// reads the slot and enqueues (single-port memories); set, wait and unknown
// commands go straight to loading. Idle comes before the next command is taken.
// A new command is taken while a result waits in the output register; a
// stalled result holds back only the next result.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module priority_task_scheduler_with_counters #(
	parameter int NUM_SLOTS           = pts_pkg::NUM_SLOTS_DEF,
	parameter int NUM_COUNTERS        = pts_pkg::NUM_COUNTERS_DEF,
	parameter int WAITERS_PER_COUNTER = pts_pkg::WAITERS_PER_COUNTER_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pts_req_if.sink    req,
	pts_rsp_if.source  rsp
);

	pts_pkg::cmd_t       cmd;
	pts_pkg::dp_status_t st;
	logic                req_ready;

	// Command sequencer.
	pts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Storage and result path.
	pts_dp #(
		.NUM_SLOTS           (NUM_SLOTS),
		.NUM_COUNTERS        (NUM_COUNTERS),
		.WAITERS_PER_COUNTER (WAITERS_PER_COUNTER)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.mode         (req.mode),
		.priority_req (req.priority_req),
		.job_tag      (req.job_tag),
		.has_counter  (req.has_counter),
		.counter_id   (req.counter_id),
		.task_id      (req.task_id),
		.count_value  (req.count_value),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.status       (rsp.status),
		.out_task     (rsp.out_task),
		.out_tag      (rsp.out_tag),
		.woken        (rsp.woken)
	);

	assign req.ready = req_ready;

endmodule
